[src/spifp_pkg.sv]
// ---------------------------------------------------------------------------
// spifp_pkg: shared definitions for the spi i/o expander frame poller
// item kinds, protocol bytes, default sizes and the status bundle
// ---------------------------------------------------------------------------
package spifp_pkg;

  // default sizes
  localparam int FRAME_BYTES_DEF     = 36;
  localparam int ANALOG_CHANNELS_DEF = 12;
  localparam int DIGITAL_INPUTS_DEF  = 4;

  // item kinds
  localparam logic [1:0] KIND_EXCHANGE = 2'd0;
  localparam logic [1:0] KIND_ANALOG   = 2'd1;
  localparam logic [1:0] KIND_DIGITAL  = 2'd2;

  // protocol bytes
  localparam logic [7:0] CMD_SET_MODE     = 8'h30;
  localparam logic [7:0] CMD_READ_ANALOG  = 8'h10;
  localparam logic [7:0] CMD_READ_DIGITAL = 8'h12;
  localparam logic [7:0] DIGITAL_MODE     = 8'h00;
  localparam logic [7:0] LEN_ANALOG       = 8'd26;
  localparam logic [7:0] LEN_DIGITAL      = 8'd25;

  // counter of set-mode frames, holds up to four inputs plus one
  localparam int SET_CNT_W = 3;

  // status of the frame engine for one item
  typedef struct packed {
    logic frame_done;     // this transfer closed the frame
    logic analog_ready;   // analog valid after this item
    logic digital_ready;  // digital valid after this item
    logic analog_valid;   // analog valid before this item
    logic digital_valid;  // digital valid before this item
  } frm_status_t;

endpackage

[src/spi_io_expander_frame_poller.sv]
// ---------------------------------------------------------------------------
// spi_io_expander_frame_poller: spi master poller for an i/o coprocessor
// builds request frames byte by byte, parses replies into a channel ram
// and digital level flops, and serves read items
// ---------------------------------------------------------------------------
// Every transfer on the item channel yields exactly one transfer on the
// result channel, in order. An exchange item (kind 0) returns the transmit
// byte for the current frame position and consumes the received byte; a
// read item (kind 1 analog, kind 2 digital) returns the stored value, or 0
// while the matching reply is not valid or the index is out of range. The
// block takes one item per clock unless the result channel stalls: the
// item is parsed in its accept cycle, an analog read is issued to the
// channel ram in that cycle, and its registered data is folded into the
// result register as the item leaves stage one. The ram holds all analog
// words and is written on the high byte of each word; per-entry valid flops
// make unwritten entries read as zero, so no clearing pass is needed after
// reset. Writes and reads of the ram come from different items and the ram
// sees a write before any later read, so no forwarding is required.
// ---------------------------------------------------------------------------
module spi_io_expander_frame_poller #(
  parameter int FRAME_BYTES     = spifp_pkg::FRAME_BYTES_DEF,
  parameter int ANALOG_CHANNELS = spifp_pkg::ANALOG_CHANNELS_DEF,
  parameter int DIGITAL_INPUTS  = spifp_pkg::DIGITAL_INPUTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  rx_byte,
  input  logic [3:0]  index,
  // result channel
  output logic        result_valid,
  input  logic        result_ready,
  output logic [7:0]  tx_byte,
  output logic        frame_done,
  output logic [15:0] millivolts,
  output logic        level,
  output logic        analog_ready,
  output logic        digital_ready
);

  localparam int CH_W = (ANALOG_CHANNELS > 1) ? $clog2(ANALOG_CHANNELS) : 1;
  localparam int DI_W = (DIGITAL_INPUTS > 1) ? $clog2(DIGITAL_INPUTS) : 1;

  // handshake
  logic accept;
  logic s1_valid;
  logic s1_adv;

  // frame engine
  logic                       xfer_en;
  logic [7:0]                 cur_tx;
  spifp_pkg::frm_status_t     status;
  logic [DIGITAL_INPUTS-1:0]  levels;
  logic                       wr_en;
  logic [CH_W-1:0]            wr_addr;
  logic [15:0]                wr_data;

  // channel ram and its entry valid bits
  logic                       rd_en;
  logic [15:0]                rd_data;
  logic [ANALOG_CHANNELS-1:0] entry_valid;

  // read qualification at accept
  logic ch_in_range;
  logic in_in_range;
  logic mv_sel;
  logic lvl_now;

  // stage one payload
  logic [7:0] s1_tx;
  logic       s1_done;
  logic       s1_mv_sel;
  logic       s1_level;
  logic       s1_aready;
  logic       s1_dready;

  // stage one moves on when the result register is free or being drained
  assign s1_adv     = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || s1_adv;
  assign accept     = item_valid && item_ready;
  assign xfer_en    = accept && (kind == spifp_pkg::KIND_EXCHANGE);
  assign rd_en      = accept && (kind == spifp_pkg::KIND_ANALOG);

  spifp_frame #(
    .FRAME_BYTES     (FRAME_BYTES),
    .ANALOG_CHANNELS (ANALOG_CHANNELS),
    .DIGITAL_INPUTS  (DIGITAL_INPUTS)
  ) u_frame (
    .clk     (clk),
    .rst     (rst),
    .xfer_en (xfer_en),
    .rx_byte (rx_byte),
    .tx_byte (cur_tx),
    .status  (status),
    .levels  (levels),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  spifp_ram #(
    .WIDTH (16),
    .DEPTH (ANALOG_CHANNELS)
  ) u_chan_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (index[CH_W-1:0]),
    .rd_data (rd_data)
  );

  // entry valid: set on first write, cleared only by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[wr_addr] <= 1'b1;
    end
  end

  // read qualification, uses state before this item (reads change nothing)
  always_comb begin
    ch_in_range = ({1'b0, index} < 5'(ANALOG_CHANNELS));
    in_in_range = ({1'b0, index} < 5'(DIGITAL_INPUTS));
    mv_sel      = (kind == spifp_pkg::KIND_ANALOG) && ch_in_range &&
                  status.analog_valid && entry_valid[index[CH_W-1:0]];
    lvl_now     = (kind == spifp_pkg::KIND_DIGITAL) && in_in_range &&
                  status.digital_valid && levels[index[DI_W-1:0]];
  end

  // stage one: item parsed, ram read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_tx     <= cur_tx;
      s1_done   <= status.frame_done;
      s1_mv_sel <= mv_sel;
      s1_level  <= lvl_now;
      s1_aready <= status.analog_ready;
      s1_dready <= status.digital_ready;
    end
  end

  // result register, ram data picked up here
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      tx_byte       <= s1_tx;
      frame_done    <= s1_done;
      millivolts    <= s1_mv_sel ? rd_data : 16'h0000;
      level         <= s1_level;
      analog_ready  <= s1_aready;
      digital_ready <= s1_dready;
    end
  end

  // ram read data must hold while its item waits in stage one
  a_rd_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> $stable(rd_data))
    else $error("ram read data changed under a stalled item");

  // a frame can only close on an exchange transfer
  a_done_kind: assert property (@(posedge clk) disable iff (rst)
    status.frame_done |-> xfer_en)
    else $error("frame done without an exchange transfer");

  // ram write and read come from different items
  a_no_rw: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("ram write and read in the same cycle");

  // an empty stage one never blocks the item channel
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> item_ready)
    else $error("item channel stalled with empty pipeline");

  // stage one hands over to the result register
  a_handover: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> result_valid)
    else $error("result lost between stages");

endmodule

[src/spifp_ram.sv]
// ---------------------------------------------------------------------------
// spifp_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle, read data holds when idle
// ---------------------------------------------------------------------------
module spifp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 12
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/spifp_frame.sv]
// ---------------------------------------------------------------------------
// spifp_frame: request sequencer and reply parser
// gives the transmit byte per position, checks the reply header and
// produces channel writes and digital levels
// ---------------------------------------------------------------------------
module spifp_frame #(
  parameter int FRAME_BYTES     = spifp_pkg::FRAME_BYTES_DEF,
  parameter int ANALOG_CHANNELS = spifp_pkg::ANALOG_CHANNELS_DEF,
  parameter int DIGITAL_INPUTS  = spifp_pkg::DIGITAL_INPUTS_DEF,
  localparam int CH_W = (ANALOG_CHANNELS > 1) ? $clog2(ANALOG_CHANNELS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        xfer_en,
  input  logic [7:0]                  rx_byte,
  output logic [7:0]                  tx_byte,
  output spifp_pkg::frm_status_t      status,
  output logic [DIGITAL_INPUTS-1:0]   levels,
  output logic                        wr_en,
  output logic [CH_W-1:0]             wr_addr,
  output logic [15:0]                 wr_data
);

  localparam int POS_W = $clog2(FRAME_BYTES);
  localparam int CIF_W = $clog2(ANALOG_CHANNELS + 1);

  // request codes
  localparam logic [1:0] REQ_SET     = 2'd0;
  localparam logic [1:0] REQ_ANALOG  = 2'd1;
  localparam logic [1:0] REQ_DIGITAL = 2'd2;

  logic [POS_W-1:0]                pos, pos_next;
  logic [1:0]                      req, req_next;
  logic [spifp_pkg::SET_CNT_W-1:0] set_cnt, set_cnt_next, set_cnt_inc;
  logic                            analog_next, analog_next_next;
  logic                            frame_ok, frame_ok_next;
  logic [7:0]                      resp_cmd, resp_cmd_next;
  logic [CIF_W-1:0]                chan_count, chan_count_next;
  logic [7:0]                      low_hold, low_hold_next;
  logic                            analog_valid, analog_valid_next;
  logic                            digital_valid, digital_valid_next;
  logic [DIGITAL_INPUTS-1:0]       levels_next;
  logic [POS_W-1:0]                k, ch;
  logic                            last;

  // transmit byte from current state
  always_comb begin
    tx_byte = 8'h00;
    if (pos == '0) begin
      if (req == REQ_SET) begin
        tx_byte = spifp_pkg::CMD_SET_MODE;
      end else if (req == REQ_ANALOG) begin
        tx_byte = spifp_pkg::CMD_READ_ANALOG;
      end else begin
        tx_byte = spifp_pkg::CMD_READ_DIGITAL;
      end
    end else if (pos == POS_W'(1) && req == REQ_SET) begin
      tx_byte = 8'(set_cnt);
    end else if (pos == POS_W'(2)) begin
      tx_byte = spifp_pkg::DIGITAL_MODE;
    end
  end

  always_comb begin
    pos_next           = pos;
    req_next           = req;
    set_cnt_next       = set_cnt;
    set_cnt_inc        = set_cnt;
    analog_next_next   = analog_next;
    frame_ok_next      = frame_ok;
    resp_cmd_next      = resp_cmd;
    chan_count_next    = chan_count;
    low_hold_next      = low_hold;
    analog_valid_next  = analog_valid;
    digital_valid_next = digital_valid;
    levels_next        = levels;
    k                  = pos - POS_W'(6);
    ch                 = k >> 1;
    last               = (pos == POS_W'(FRAME_BYTES - 1));
    wr_en              = 1'b0;
    wr_addr            = ch[CH_W-1:0];
    wr_data            = {rx_byte, low_hold};

    if (xfer_en) begin
      // header checks
      if (pos == '0) begin
        frame_ok_next = (rx_byte == 8'h00) || (rx_byte == 8'h01);
      end else if (pos == POS_W'(1)) begin
        if (rx_byte != 8'h00) frame_ok_next = 1'b0;
      end else if (pos == POS_W'(2)) begin
        resp_cmd_next = rx_byte;
      end else if (pos == POS_W'(3)) begin
        if (resp_cmd == spifp_pkg::CMD_READ_ANALOG && rx_byte != spifp_pkg::LEN_ANALOG)
          frame_ok_next = 1'b0;
        if (resp_cmd == spifp_pkg::CMD_READ_DIGITAL && rx_byte != spifp_pkg::LEN_DIGITAL)
          frame_ok_next = 1'b0;
      end else if (resp_cmd == spifp_pkg::CMD_READ_ANALOG) begin
        if (pos == POS_W'(4)) begin
          if (rx_byte == 8'h00) frame_ok_next = 1'b0;
        end else if (pos == POS_W'(5)) begin
          if (rx_byte < 8'(ANALOG_CHANNELS)) begin
            chan_count_next = CIF_W'(rx_byte);
          end else begin
            chan_count_next = CIF_W'(ANALOG_CHANNELS);
          end
        end else if (frame_ok && ch < POS_W'(chan_count)) begin
          // low byte first, word goes to the ram on the high byte
          if (!k[0]) begin
            low_hold_next = rx_byte;
          end else begin
            wr_en = 1'b1;
          end
        end
      end else if (resp_cmd == spifp_pkg::CMD_READ_DIGITAL) begin
        if (pos == POS_W'(4)) begin
          if (rx_byte != 8'(DIGITAL_INPUTS)) frame_ok_next = 1'b0;
        end else begin
          for (int i = 0; i < DIGITAL_INPUTS; i++) begin
            if (frame_ok && pos == POS_W'(6 + 6 * i)) levels_next[i] = rx_byte[0];
          end
        end
      end

      // end of frame
      if (last) begin
        if (resp_cmd_next == spifp_pkg::CMD_READ_ANALOG) begin
          analog_valid_next = frame_ok_next;
        end else if (resp_cmd_next == spifp_pkg::CMD_READ_DIGITAL) begin
          digital_valid_next = frame_ok_next;
        end
        pos_next      = '0;
        frame_ok_next = 1'b0;
        resp_cmd_next = 8'h00;
        if (req == REQ_SET) begin
          if (set_cnt <= spifp_pkg::SET_CNT_W'(DIGITAL_INPUTS))
            set_cnt_inc = set_cnt + spifp_pkg::SET_CNT_W'(1);
          set_cnt_next = set_cnt_inc;
          if (set_cnt_inc > spifp_pkg::SET_CNT_W'(DIGITAL_INPUTS)) begin
            req_next         = analog_next ? REQ_ANALOG : REQ_DIGITAL;
            analog_next_next = !analog_next;
          end
        end else begin
          req_next         = analog_next ? REQ_ANALOG : REQ_DIGITAL;
          analog_next_next = !analog_next;
        end
      end else begin
        pos_next = pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      req           <= REQ_SET;
      set_cnt       <= spifp_pkg::SET_CNT_W'(1);
      analog_next   <= 1'b1;
      frame_ok      <= 1'b0;
      resp_cmd      <= 8'h00;
      chan_count    <= '0;
      low_hold      <= 8'h00;
      analog_valid  <= 1'b0;
      digital_valid <= 1'b0;
      levels        <= '0;
    end else begin
      pos           <= pos_next;
      req           <= req_next;
      set_cnt       <= set_cnt_next;
      analog_next   <= analog_next_next;
      frame_ok      <= frame_ok_next;
      resp_cmd      <= resp_cmd_next;
      chan_count    <= chan_count_next;
      low_hold      <= low_hold_next;
      analog_valid  <= analog_valid_next;
      digital_valid <= digital_valid_next;
      levels        <= levels_next;
    end
  end

  always_comb begin
    status.frame_done    = xfer_en && last;
    status.analog_ready  = analog_valid_next;
    status.digital_ready = digital_valid_next;
    status.analog_valid  = analog_valid;
    status.digital_valid = digital_valid;
  end

endmodule
